// ===== rtl/lfrr_pkg.sv =====
// Shared types and constants for the line-framed receive ring.
// Used by lfrr_ctrl, lfrr_dp and line_framed_receive_ring_top; no dependencies.
package lfrr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 8;
    // Scan counter width: enough for MAX_RESULTS
    localparam int CNT_W  = 6;

    localparam logic [BYTE_W-1:0] LINE_TERM    = 8'h0d;
    localparam logic [CNT_W-1:0]  MAX_RESULTS  = 6'd63;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 8'd255;

    localparam logic FUNC_STORE   = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store;     // write the received byte, advance the write pointer
        logic load;      // walk pointer <= read pointer, counter <= 0
        logic rd;        // read the ring at the walk pointer
        logic adv;       // advance the walk pointer and counter
        logic commit;    // read pointer <= next of walk pointer
        logic emit;      // present a line byte
        logic notfound;  // present a not-found result
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic stop;      // nothing unread left or scan limit reached
        logic is_term;   // byte just read is the line terminator
    } t_dp_sts;

endpackage

// ===== rtl/lfrr_ctrl.sv =====
// Controller state machine of the line-framed receive ring.
// Depends on lfrr_pkg; drives lfrr_dp through t_dp_cmd and reads t_dp_sts.
module lfrr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_func,
    input  lfrr_pkg::t_dp_sts i_sts,
    output lfrr_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);
    import lfrr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && i_func == FUNC_REQUEST) n_state = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                n_state = i_sts.stop ? ST_IDLE : ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                n_state = i_sts.is_term ? ST_EMIT_RD : ST_SCAN_RD;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                n_state = i_sts.is_term ? ST_IDLE : ST_EMIT_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.store = i_start && (i_func == FUNC_STORE);
                o_cmd.load  = i_start && (i_func == FUNC_REQUEST);
            end
            ST_SCAN_RD: begin
                o_cmd.notfound = i_sts.stop;
                o_cmd.rd       = !i_sts.stop;
            end
            ST_SCAN_CHK: begin
                // rewind for the emit pass once the terminator is seen
                o_cmd.load = i_sts.is_term;
                o_cmd.adv  = !i_sts.is_term;
            end
            ST_EMIT_RD: begin
                o_cmd.rd = 1'b1;
            end
            ST_EMIT_OUT: begin
                o_cmd.emit   = 1'b1;
                o_cmd.adv    = 1'b1;
                o_cmd.commit = i_sts.is_term;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/lfrr_dp.sv =====
// Datapath of the line-framed receive ring: ring memory, pointers, scan
// counter, length register and result registers. Depends on lfrr_pkg.
module lfrr_dp #(
    parameter int RING_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lfrr_pkg::t_dp_cmd           i_cmd,
    output lfrr_pkg::t_dp_sts           o_sts,
    input  logic [lfrr_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                        i_cfg_we,
    input  logic [lfrr_pkg::LEN_W-1:0]  i_cfg_data,
    output logic                        o_strobe,
    output logic                        o_line_found,
    output logic [lfrr_pkg::BYTE_W-1:0] o_line_byte,
    output logic                        o_last_of_line
);
    import lfrr_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0] PTR_LAST = AW'(RING_DEPTH - 1);

    logic [BYTE_W-1:0] r_ring [RING_DEPTH];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [AW-1:0]     r_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic [BYTE_W-1:0] r_rdata;
    logic [LEN_W-1:0]  r_max_len;
    logic              r_strobe;
    logic              r_found;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    logic [AW-1:0]     n_wp;
    logic [AW-1:0]     n_ptr;
    logic [CNT_W-1:0]  n_limit;

    assign n_wp  = (r_wp  == PTR_LAST) ? '0 : r_wp  + AW'(1);
    assign n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + AW'(1);

    // clamp the length register to 1..MAX_RESULTS
    always_comb begin
        if (r_max_len == '0) begin
            n_limit = CNT_W'(1);
        end else if (r_max_len > LEN_W'(MAX_RESULTS)) begin
            n_limit = MAX_RESULTS;
        end else begin
            n_limit = r_max_len[CNT_W-1:0];
        end
    end

    assign o_sts.stop    = (r_ptr == r_wp) || (r_cnt >= n_limit);
    assign o_sts.is_term = (r_rdata == LINE_TERM);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_ring[r_wp] <= i_rx_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_ring[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ptr <= r_rp;
            r_cnt <= '0;
        end else if (i_cmd.adv) begin
            r_ptr <= n_ptr;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_byte <= r_rdata;
        end else begin
            r_byte <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_max_len <= MAX_LEN_RST;
            r_strobe  <= 1'b0;
            r_found   <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            if (i_cmd.store) r_wp <= n_wp;
            if (i_cmd.commit) r_rp <= n_ptr;
            if (i_cfg_we) r_max_len <= i_cfg_data;
            r_strobe <= i_cmd.emit || i_cmd.notfound;
            r_found  <= i_cmd.emit;
            r_last   <= i_cmd.notfound || (i_cmd.emit && o_sts.is_term);
        end
    end

    assign o_strobe       = r_strobe;
    assign o_line_found   = r_found;
    assign o_line_byte    = r_byte;
    assign o_last_of_line = r_last;

endmodule

// ===== rtl/line_framed_receive_ring_top.sv =====
// Top level of the line-framed receive ring: controller plus datapath.
// Depends on lfrr_pkg, lfrr_ctrl and lfrr_dp.
//
// Command channel: drive i_func/i_rx_byte with start high; the transfer is
//   taken at a rising edge where busy is low. i_func = 0 stores a byte,
//   i_func = 1 asks for one CR-terminated line.
// Result channel: each result sits on o_line_found/o_line_byte/o_last_of_line
//   for exactly one cycle, flagged by o_result_strobe. The receiver cannot
//   stall, so it must take every strobe. o_last_of_line marks the CR of a line
//   or the single not-found result.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_data write the maximum
//   line length; o_cfg_ready is always high. Write only when idle.
// Timing: a store leaves busy low, so stores run back to back.
//   The ring has one read port with registered data, so the scan pass and the
//   emit pass each spend a read state and a check or output state per byte.
//   The scan pass walks to the CR; the walk pointer then rewinds to the read
//   pointer and the emit pass reads the line again, presenting each byte.
//   The final result of a request is registered on the edge at which busy falls.
// Reset: synchronous, active low. Write and read pointers clear (ring reads empty),
//   the length register returns to 255, the controller goes idle; ring contents are kept.
module line_framed_receive_ring_top #(
    parameter int RING_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [lfrr_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lfrr_pkg::LEN_W-1:0]  i_cfg_data,
    output logic                        o_result_strobe,
    output logic                        o_line_found,
    output logic [lfrr_pkg::BYTE_W-1:0] o_line_byte,
    output logic                        o_last_of_line
);
    import lfrr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    ctrl_busy;
    logic    cmd_start;

    // hold off commands while a request is being walked
    assign cmd_start   = start && !ctrl_busy;
    assign busy        = ctrl_busy;
    // the length register takes a transfer in any cycle
    assign o_cfg_ready = 1'b1;

    lfrr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cmd_start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    lfrr_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_result_strobe),
        .o_line_found   (o_line_found),
        .o_line_byte    (o_line_byte),
        .o_last_of_line (o_last_of_line)
    );

    // a not-found result is a lone, zero, terminating result
    a_notfound_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_line_found |-> o_last_of_line && o_line_byte == '0)
        else $error("not-found result malformed");

    // busy only rises after an accepted line request
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_func == FUNC_REQUEST))
        else $error("busy rose without a line request");

    // the end of a result burst is never directly followed by another result
    a_burst_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_last_of_line |=> !o_result_strobe)
        else $error("result straight after end of burst");

    // results appear only while a request is in progress or just finished
    a_strobe_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result strobe without a request in progress");

endmodule
